>>> hw/rtl/alad_pkg.sv
// Shared types, constants and the gamma curve table of the ambient light auto dimmer.
// Depends on nothing; the top level, the divider and the checker refer to it by scoped names.
`default_nettype none

package alad_pkg;

    // Block configuration.
    localparam int WINDOW          = 16;
    localparam int SAMPLE_BITS     = 12;
    localparam int GAMMA_TENTHS    = 22;
    localparam int CURVE_ADDR_BITS = 8;
    localparam int CURVE_FRAC      = 16;
    localparam int CURVE_SIZE      = 1 << CURVE_ADDR_BITS;
    localparam int CURVE_TOP       = CURVE_SIZE - 1;
    localparam int CURVE_W         = CURVE_FRAC + 1;
    localparam logic [7:0] DUTY_AT_RESET = 8'd128;

    // Port field widths.
    localparam int LIGHT_W    = 12;
    localparam int THR_W      = 12;
    localparam int DUTY_W     = 8;
    localparam int MEAN_W     = 12;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Derived datapath widths.
    localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int COUNT_W   = $clog2(WINDOW + 1);
    localparam int TOTAL_W   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int CMP_W     = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam int NUM_W     = CMP_W + CURVE_ADDR_BITS;
    localparam int DVD_W     = (TOTAL_W > NUM_W) ? TOTAL_W : NUM_W;
    localparam int DVS_W     = (THR_W > COUNT_W) ? THR_W : COUNT_W;
    localparam int DIV_STEPS = (DVD_W + 1) / 2;
    localparam int DIV_PAD_W = 2 * DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int PROD_W    = CURVE_W + DUTY_W;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_DARK    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BRIGHT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FLOOR   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CEILING = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SLEW    = 3'd4;

    localparam logic [THR_W-1:0]  DARK_RESET    = 12'd500;
    localparam logic [THR_W-1:0]  BRIGHT_RESET  = 12'd3000;
    localparam logic [DUTY_W-1:0] FLOOR_RESET   = 8'd10;
    localparam logic [DUTY_W-1:0] CEILING_RESET = 8'd255;
    localparam logic [DUTY_W-1:0] SLEW_RESET    = 8'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_COMPARE,
        ST_IDX_GO,
        ST_IDX_WAIT,
        ST_GAMMA,
        ST_SCALE,
        ST_SLEW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_stat_t;

    // Normalised product form used to build the gamma curve at elaboration.
    typedef struct packed {
        logic [63:0] m;
        int          e;
        logic        nz;
    } xnum_t;

    typedef logic [CURVE_W-1:0] gamma_rom_t [CURVE_SIZE];

    function automatic xnum_t xn_from(logic [63:0] v);
        xnum_t r;
        r.m  = v;
        r.e  = 0;
        r.nz = (v != 64'd0);
        if (r.nz) begin
            for (int k = 0; k < 64; k++) begin
                if (r.m < 64'h8000_0000) begin
                    r.m = r.m << 1;
                    r.e = r.e - 1;
                end
            end
        end
        return r;
    endfunction

    function automatic xnum_t xn_mul(xnum_t a, xnum_t b);
        xnum_t       r;
        logic [63:0] p;
        if (!a.nz || !b.nz) begin
            r = xn_from(64'd0);
        end else begin
            p    = a.m * b.m;
            r.nz = 1'b1;
            if (p[63]) begin
                r.m = p >> 32;
                r.e = a.e + b.e + 32;
            end else begin
                r.m = p >> 31;
                r.e = a.e + b.e + 31;
            end
        end
        return r;
    endfunction

    function automatic xnum_t xn_pow(xnum_t a, int n);
        xnum_t r;
        r = xn_from(64'd1);
        for (int k = 0; k < n; k++) begin
            r = xn_mul(r, a);
        end
        return r;
    endfunction

    function automatic logic xn_le(xnum_t a, xnum_t b);
        logic le;
        if (!a.nz) begin
            le = 1'b1;
        end else if (!b.nz) begin
            le = 1'b0;
        end else if (a.e != b.e) begin
            le = (a.e < b.e);
        end else begin
            le = (a.m <= b.m);
        end
        return le;
    endfunction

    // Entry i is the largest Y with Y^GAMMA_TENTHS * TOP^10 <= i^10 * 2^(16*GAMMA_TENTHS),
    // found by a binary search over the Q1.16 range from 0 to 1.0.
    function automatic gamma_rom_t build_gamma_rom();
        gamma_rom_t  rom;
        xnum_t       top10;
        xnum_t       rhs;
        xnum_t       lhs;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        top10  = xn_pow(xn_from(64'(CURVE_TOP)), 10);
        rom[0] = '0;
        for (int i = 1; i < CURVE_SIZE; i++) begin
            rhs   = xn_pow(xn_from(64'(i)), 10);
            rhs.e = rhs.e + CURVE_FRAC * GAMMA_TENTHS;
            lo    = 32'd0;
            hi    = 32'd1 << CURVE_FRAC;
            for (int k = 0; k < CURVE_FRAC + 2; k++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 32'd1) >> 1;
                    lhs = xn_mul(xn_pow(xn_from(64'(mid)), GAMMA_TENTHS), top10);
                    if (xn_le(lhs, rhs)) begin
                        lo = mid;
                    end else begin
                        hi = mid - 32'd1;
                    end
                end
            end
            rom[i] = lo[CURVE_W-1:0];
        end
        return rom;
    endfunction

    localparam gamma_rom_t GAMMA_ROM = build_gamma_rom();

endpackage

`default_nettype wire

>>> hw/rtl/ambient_light_auto_dimmer.sv
// Top level of the ambient light auto dimmer: sample ring, moving average, gamma
// mapping and slew limiting. Depends on alad_pkg, alad_ram and alad_div.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_tvalid/s_tready  light_sample
//   m_        out        m_tvalid/m_tready  duty, target_level, mean_light
//   APB       in         psel/penable       five configuration registers
//
// A mean between two unequal thresholds makes two passes through the two-bit-per-cycle
// divider (mean, then curve index); a mean outside the thresholds, or equal thresholds,
// skip the index pass. The input is ready again in the cycle after the result is loaded
// into the output register. A finished result waits in the output register while the
// next sample is worked on; a stall holds the block only when a second result is ready
// before the first has been taken.
// Reset is synchronous and active low; the sample ring needs no clearing pass.
`default_nettype none

module ambient_light_auto_dimmer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input beats.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [alad_pkg::S_TDATA_W-1:0]  s_tdata,   // [11:0] light_sample
    // Result beats.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [alad_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] duty,
                                                             // [15:8] target_level,
                                                             // [27:16] mean_light
    // Configuration.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [alad_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [alad_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [alad_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Index is the word address.
    // ------------------------------------------------------------------
    logic [alad_pkg::THR_W-1:0]     dark_reg;
    logic [alad_pkg::THR_W-1:0]     bright_reg;
    logic [alad_pkg::DUTY_W-1:0]    floor_reg;
    logic [alad_pkg::DUTY_W-1:0]    ceiling_reg;
    logic [alad_pkg::DUTY_W-1:0]    slew_reg;
    logic [alad_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[alad_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_reg    <= alad_pkg::DARK_RESET;
            bright_reg  <= alad_pkg::BRIGHT_RESET;
            floor_reg   <= alad_pkg::FLOOR_RESET;
            ceiling_reg <= alad_pkg::CEILING_RESET;
            slew_reg    <= alad_pkg::SLEW_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                alad_pkg::REG_DARK:    dark_reg    <= pwdata[alad_pkg::THR_W-1:0];
                alad_pkg::REG_BRIGHT:  bright_reg  <= pwdata[alad_pkg::THR_W-1:0];
                alad_pkg::REG_FLOOR:   floor_reg   <= pwdata[alad_pkg::DUTY_W-1:0];
                alad_pkg::REG_CEILING: ceiling_reg <= pwdata[alad_pkg::DUTY_W-1:0];
                alad_pkg::REG_SLEW:    slew_reg    <= pwdata[alad_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            alad_pkg::REG_DARK:    prdata = alad_pkg::APB_DATA_W'(dark_reg);
            alad_pkg::REG_BRIGHT:  prdata = alad_pkg::APB_DATA_W'(bright_reg);
            alad_pkg::REG_FLOOR:   prdata = alad_pkg::APB_DATA_W'(floor_reg);
            alad_pkg::REG_CEILING: prdata = alad_pkg::APB_DATA_W'(ceiling_reg);
            alad_pkg::REG_SLEW:    prdata = alad_pkg::APB_DATA_W'(slew_reg);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers.
    // ------------------------------------------------------------------
    alad_pkg::state_t state_reg, state_next;

    logic [alad_pkg::SAMPLE_BITS-1:0]     sample_reg;
    logic [alad_pkg::PTR_W-1:0]           ptr_reg;
    logic                                 full_reg;
    logic [alad_pkg::TOTAL_W-1:0]         total_reg;
    logic [alad_pkg::COUNT_W-1:0]         count_reg;
    logic [alad_pkg::SAMPLE_BITS-1:0]     mean_reg;
    logic [alad_pkg::NUM_W-1:0]           num_reg;
    logic [alad_pkg::THR_W-1:0]           span_reg;
    logic [alad_pkg::CURVE_ADDR_BITS-1:0] idx_reg;
    logic [alad_pkg::PROD_W-1:0]          prod_reg;
    logic [alad_pkg::DUTY_W-1:0]          target_reg;
    logic [alad_pkg::DUTY_W-1:0]          duty_reg;
    logic                                 m_tvalid_reg;
    logic [alad_pkg::M_TDATA_W-1:0]       m_tdata_reg;

    // Control strobes decoded from the state.
    logic ram_re;
    logic ram_we;
    logic mean_go;
    logic idx_go;
    logic out_load;

    // Memory and divider connections.
    logic [alad_pkg::SAMPLE_BITS-1:0] ram_rdata;
    alad_pkg::div_req_t               div_req;
    alad_pkg::div_stat_t              div_stat;

    // Comparisons of the mean against the thresholds.
    logic [alad_pkg::CMP_W-1:0] mean_cmp;
    logic [alad_pkg::CMP_W-1:0] dark_cmp;
    logic [alad_pkg::CMP_W-1:0] bright_cmp;
    logic                       below_dark;
    logic                       above_bright;

    assign mean_cmp     = alad_pkg::CMP_W'(mean_reg);
    assign dark_cmp     = alad_pkg::CMP_W'(dark_reg);
    assign bright_cmp   = alad_pkg::CMP_W'(bright_reg);
    assign below_dark   = (mean_cmp < dark_cmp);
    assign above_bright = (mean_cmp > bright_cmp);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            alad_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = alad_pkg::ST_READ;
                end
            end
            alad_pkg::ST_READ:      state_next = alad_pkg::ST_UPDATE;
            alad_pkg::ST_UPDATE:    state_next = alad_pkg::ST_MEAN_GO;
            alad_pkg::ST_MEAN_GO:   state_next = alad_pkg::ST_MEAN_WAIT;
            alad_pkg::ST_MEAN_WAIT: begin
                if (div_stat.done) begin
                    state_next = alad_pkg::ST_COMPARE;
                end
            end
            alad_pkg::ST_COMPARE: begin
                if (below_dark || above_bright) begin
                    state_next = alad_pkg::ST_SLEW;
                end else if (bright_reg == dark_reg) begin
                    state_next = alad_pkg::ST_GAMMA;
                end else begin
                    state_next = alad_pkg::ST_IDX_GO;
                end
            end
            alad_pkg::ST_IDX_GO:    state_next = alad_pkg::ST_IDX_WAIT;
            alad_pkg::ST_IDX_WAIT: begin
                if (div_stat.done) begin
                    state_next = alad_pkg::ST_GAMMA;
                end
            end
            alad_pkg::ST_GAMMA:     state_next = alad_pkg::ST_SCALE;
            alad_pkg::ST_SCALE:     state_next = alad_pkg::ST_SLEW;
            alad_pkg::ST_SLEW:      state_next = alad_pkg::ST_OUT;
            alad_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = alad_pkg::ST_IDLE;
                end
            end
            default:                state_next = alad_pkg::ST_IDLE;
        endcase
    end

    // Strobes.
    always_comb begin
        s_tready = 1'b0;
        ram_re   = 1'b0;
        ram_we   = 1'b0;
        mean_go  = 1'b0;
        idx_go   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            alad_pkg::ST_IDLE:    s_tready = 1'b1;
            alad_pkg::ST_READ:    ram_re   = 1'b1;
            alad_pkg::ST_UPDATE:  ram_we   = 1'b1;
            alad_pkg::ST_MEAN_GO: mean_go  = 1'b1;
            alad_pkg::ST_IDX_GO:  idx_go   = 1'b1;
            alad_pkg::ST_OUT:     out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= alad_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Ring bookkeeping and running total. Once the ring has wrapped, the entry about
    // to be overwritten leaves the total before the new sample enters it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            full_reg  <= 1'b0;
            total_reg <= '0;
            count_reg <= '0;
        end else if (ram_we) begin
            total_reg <= total_reg
                         - (full_reg ? alad_pkg::TOTAL_W'(ram_rdata) : '0)
                         + alad_pkg::TOTAL_W'(sample_reg);
            if (ptr_reg == alad_pkg::PTR_W'(alad_pkg::WINDOW - 1)) begin
                ptr_reg   <= '0;
                full_reg  <= 1'b1;
                count_reg <= alad_pkg::COUNT_W'(alad_pkg::WINDOW);
            end else begin
                ptr_reg   <= ptr_reg + 1'b1;
                count_reg <= full_reg ? alad_pkg::COUNT_W'(alad_pkg::WINDOW)
                                      : alad_pkg::COUNT_W'(ptr_reg) + 1'b1;
            end
        end
    end

    alad_ram #(
        .WIDTH (alad_pkg::SAMPLE_BITS),
        .DEPTH (alad_pkg::WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // The divider is shared: the mean first, then the curve index.
    always_comb begin
        div_req.start    = mean_go || idx_go;
        div_req.dividend = idx_go ? alad_pkg::DVD_W'(num_reg)
                                  : alad_pkg::DVD_W'(total_reg);
        div_req.divisor  = idx_go ? alad_pkg::DVS_W'(span_reg)
                                  : alad_pkg::DVS_W'(count_reg);
    end

    alad_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .stat    (div_stat)
    );

    // Payload path.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= alad_pkg::SAMPLE_BITS'(s_tdata[alad_pkg::LIGHT_W-1:0]);
        end
        if (state_reg == alad_pkg::ST_MEAN_WAIT && div_stat.done) begin
            mean_reg <= div_stat.quotient[alad_pkg::SAMPLE_BITS-1:0];
        end
        if (state_reg == alad_pkg::ST_COMPARE) begin
            // Between the thresholds the mean is at least the dark threshold.
            num_reg  <= alad_pkg::NUM_W'(mean_cmp - dark_cmp)
                        * alad_pkg::NUM_W'(alad_pkg::CURVE_TOP);
            span_reg <= bright_reg - dark_reg;
            idx_reg  <= '0;
            if (below_dark) begin
                target_reg <= floor_reg;
            end else if (above_bright) begin
                target_reg <= ceiling_reg;
            end
        end
        if (state_reg == alad_pkg::ST_IDX_WAIT && div_stat.done) begin
            idx_reg <= div_stat.quotient[alad_pkg::CURVE_ADDR_BITS-1:0];
        end
        if (state_reg == alad_pkg::ST_GAMMA) begin
            // A ceiling that is not above the floor leaves the floor as target.
            prod_reg <= alad_pkg::PROD_W'(alad_pkg::GAMMA_ROM[idx_reg])
                        * alad_pkg::PROD_W'((ceiling_reg > floor_reg)
                                            ? (ceiling_reg - floor_reg)
                                            : alad_pkg::DUTY_W'(0));
        end
        if (state_reg == alad_pkg::ST_SCALE) begin
            target_reg <= floor_reg
                          + prod_reg[alad_pkg::CURVE_FRAC +: alad_pkg::DUTY_W];
        end
    end

    // Slew limiting towards the target, saturating and clamped at the target.
    logic [alad_pkg::DUTY_W:0]   duty_up;
    logic [alad_pkg::DUTY_W-1:0] duty_step;

    always_comb begin
        duty_up   = {1'b0, duty_reg} + {1'b0, slew_reg};
        duty_step = duty_reg;
        if (target_reg > duty_reg) begin
            duty_step = duty_up[alad_pkg::DUTY_W] ? '1 : duty_up[alad_pkg::DUTY_W-1:0];
            if (duty_step > target_reg) begin
                duty_step = target_reg;
            end
        end else if (target_reg < duty_reg) begin
            duty_step = (duty_reg >= slew_reg) ? (duty_reg - slew_reg) : '0;
            if (duty_step < target_reg) begin
                duty_step = target_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg <= alad_pkg::DUTY_AT_RESET;
        end else if (state_reg == alad_pkg::ST_SLEW) begin
            duty_reg <= duty_step;
        end
    end

    // Output register: holds a finished beat while the next sample is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {4'd0,
                            alad_pkg::MEAN_W'(mean_reg),
                            target_reg,
                            duty_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/alad_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module alad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/alad_div.sv
// Iterative restoring divider, two quotient bits per cycle, shared by the mean and
// the curve index. Depends on alad_pkg.
`default_nettype none

module alad_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire alad_pkg::div_req_t  req,
    output alad_pkg::div_stat_t      stat
);

    logic [alad_pkg::DIV_PAD_W-1:0] quo_reg, quo_next;
    logic [alad_pkg::DVS_W:0]       rem_reg, rem_next;
    logic [alad_pkg::DVS_W-1:0]     dvs_reg;
    logic [alad_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    // Two dependent compare-and-subtract steps.
    always_comb begin
        logic [alad_pkg::DVS_W:0]       r;
        logic [alad_pkg::DIV_PAD_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int j = 0; j < 2; j++) begin
            r = {r[alad_pkg::DVS_W-1:0], q[alad_pkg::DIV_PAD_W-1]};
            q = q << 1;
            if (r >= {1'b0, dvs_reg}) begin
                r    = r - {1'b0, dvs_reg};
                q[0] = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= alad_pkg::DIV_CNT_W'(alad_pkg::DIV_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == alad_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= alad_pkg::DIV_PAD_W'(req.dividend);
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg[alad_pkg::DVD_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/alad_checker.sv
// Port-level checks for the ambient light auto dimmer, bound to its top level.
// Depends on alad_pkg and ambient_light_auto_dimmer.
`default_nettype none

module alad_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [alad_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // One sample at a time: acceptance closes the input side for the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample is in work");

    // Reset leaves the block ready for a sample and with no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not idle after reset");

    // The bits above the mean are padding and stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:28] == 4'd0)
        else $error("result padding not zero");

endmodule

bind ambient_light_auto_dimmer alad_checker u_alad_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
